FILE: rtl/core/sps_pkg.sv
package sps_pkg;

    // Default sizes handed to the top level's parameters.
    localparam int NUM_SPHERES_DEF = 8;
    localparam int IMAGE_DIM_DEF   = 1024;

    // Field widths fixed by the word layout.
    localparam int SLOT_W  = 3;
    localparam int CHAN_W  = 8;
    localparam int COORD_W = 10;
    localparam int ADDR_W  = 22;

    // Squared distance of two coordinates, and the sum of two of them.
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    // Root unit works on 16-bit operands and gives an 8-bit root.
    localparam int ROOT_IN_W  = 2 * CHAN_W;
    localparam int ROOT_OUT_W = CHAN_W;

    // Shadow weight applied to the distance, and the largest channel value.
    localparam int SHADOW       = 3;
    localparam int CHAN_MAX     = 255;
    localparam int SHADE_LIMIT  = CHAN_MAX * CHAN_MAX;
    localparam int ALPHA_OPAQUE = 255;

    // Operation carried in tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SHADE = 1'b1;

    // One entry of the sphere table.
    typedef struct packed {
        logic [CHAN_W-1:0]  radius;
        logic [CHAN_W-1:0]  depth;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
    } sphere_t;

    // Status handed back by the root unit.
    typedef struct packed {
        logic                  done;
        logic                  inexact;
        logic [ROOT_OUT_W-1:0] floor_root;
    } root_res_t;

endpackage

FILE: rtl/core/sps_sphere_table.sv
module sps_sphere_table #(
    parameter int DEPTH = sps_pkg::NUM_SPHERES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [sps_pkg::SLOT_W-1:0]  wr_slot,
    input  sps_pkg::sphere_t            wr_entry,
    input  logic [AW-1:0]               rd_idx,
    output sps_pkg::sphere_t            rd_entry
);

    sps_pkg::sphere_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    sps_pkg::sphere_t rd_entry_reg;
    logic             wr_ok;
    logic [AW-1:0]    wr_idx;

    // Slots beyond the table are dropped.
    assign wr_ok  = wr_en && ({4'b0, wr_slot} < 7'(DEPTH));
    assign wr_idx = AW'(wr_slot);

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_idx] <= wr_entry;
        end
    end

    // An entry that was never loaded reads as all zeros.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_ok) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_entry_reg <= valid_reg[rd_idx] ? mem[rd_idx] : '0;
    end

    assign rd_entry = rd_entry_reg;

endmodule

FILE: rtl/core/sps_square_unit.sv
module sps_square_unit (
    input  logic                         aclk,
    input  logic [sps_pkg::COORD_W-1:0]  operand,
    output logic [sps_pkg::SQ_W-1:0]     square
);

    logic [sps_pkg::SQ_W-1:0] square_reg;

    // Shared squarer, one product a cycle with the result registered.
    always_ff @(posedge aclk) begin
        square_reg <= sps_pkg::SQ_W'(operand) * sps_pkg::SQ_W'(operand);
    end

    assign square = square_reg;

endmodule

FILE: rtl/core/sps_root_unit.sv
module sps_root_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sps_pkg::ROOT_IN_W-1:0]  operand,
    output sps_pkg::root_res_t             result
);

    localparam int RW = sps_pkg::ROOT_IN_W;

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW:0]   trial;

    // One digit of the root per cycle, highest digit first.
    always_comb begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        if (start) begin
            rem_next  = operand;
            root_next = '0;
            bit_next  = RW'(1) << (RW - 2);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_next  = rem_reg - trial[RW-1:0];
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == RW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign result.done       = done_reg;
    assign result.inexact    = (rem_reg != '0);
    assign result.floor_root = root_reg[sps_pkg::ROOT_OUT_W-1:0];

endmodule

FILE: rtl/core/sphere_pixel_shader_unit.sv
// Sphere pixel shader. A load word (tuser = 0) writes one sphere into the
// table slot named in tdata and gives no result; the table is all zeros after
// reset. A shade word (tuser = 1) walks the table from slot 0 upwards and
// gives one result word with the framebuffer byte address, the shaded red,
// green and blue channels, and alpha 255. A load word leaves s_tready high.
// A shade word holds s_tready low while it walks the table and until the
// finished pixel has been written into the result register, which may wait
// for that register to empty. Each sphere costs a table read and three passes
// through the shared squarer, and a hit sphere whose weighted distance
// 9 * d^2 stays below 255^2 also runs the bit-serial square root, one digit
// a cycle. The result register lets the next word be taken while a result
// waits.
module sphere_pixel_shader_unit #(
    parameter int NUM_SPHERES = sps_pkg::NUM_SPHERES_DEF,
    parameter int IMAGE_DIM   = sps_pkg::IMAGE_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata fields from bit 0: sphere_slot, sphere_red, sphere_green,
    // sphere_blue, sphere_x, sphere_y, sphere_depth, sphere_radius,
    // pixel_row, pixel_col, zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    // s_tuser fields from bit 0: operation
    input  logic [0:0]  s_tuser,
    // m_tdata fields from bit 0: byte_address, red, green, blue, alpha,
    // zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);

    localparam int IDX_W  = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
    localparam int CW     = sps_pkg::CHAN_W;
    localparam int XW     = sps_pkg::COORD_W;
    localparam int DW     = sps_pkg::DIST_W;
    localparam int WDW    = DW + 4;
    localparam int WEIGHT = sps_pkg::SHADOW * sps_pkg::SHADOW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SQX,
        S_SQY,
        S_RSQ,
        S_HIT,
        S_ROOT,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [XW-1:0]        row_reg, row_next;
    logic [XW-1:0]        col_reg, col_next;
    logic [DW-1:0]        dist_reg, dist_next;
    logic [CW-1:0]        red_reg, red_next;
    logic [CW-1:0]        green_reg, green_next;
    logic [CW-1:0]        blue_reg, blue_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [55:0]          m_tdata_reg, m_tdata_next;

    logic                 accept;
    logic                 in_op;
    logic [2:0]           in_slot;
    sps_pkg::sphere_t     in_entry;
    logic [XW-1:0]        in_row;
    logic [XW-1:0]        in_col;
    sps_pkg::sphere_t     entry;
    logic                 tbl_wr;
    logic [XW-1:0]        dx;
    logic [XW-1:0]        dy;
    logic [XW-1:0]        sq_operand;
    logic [sps_pkg::SQ_W-1:0] square;
    logic [WDW-1:0]       weighted;
    logic                 hit;
    logic                 in_range;
    logic                 root_start;
    sps_pkg::root_res_t   root_res;
    logic                 zero_dist;
    logic [31:0]          pixel_index;
    logic [sps_pkg::ADDR_W-1:0] byte_addr;
    logic                 last_sphere;

    // One channel against one hit sphere; keeps the old value when the channel
    // less depth is not above the floor of the root or the shaded value is 255.
    function automatic logic [CW-1:0] shade_chan(
        input logic [CW-1:0] cur,
        input logic [CW-1:0] chan,
        input logic [CW-1:0] depth,
        input logic [CW-1:0] froot,
        input logic          inexact,
        input logic          zero_d
    );
        logic [CW:0] base;
        logic [CW:0] ceil_root;
        logic [CW:0] diff;
        base      = {1'b0, chan} - {1'b0, depth};
        ceil_root = {1'b0, froot} + {{CW{1'b0}}, inexact};
        diff      = base - ceil_root;
        if (base[CW] || (base == '0) || (base <= {1'b0, froot}) ||
            ((base == (CW+1)'(sps_pkg::CHAN_MAX)) && zero_d)) begin
            return cur;
        end
        return diff[CW-1:0];
    endfunction

    // Unpack the input word.
    assign in_op           = s_tuser[0];
    assign in_slot         = s_tdata[2:0];
    assign in_entry.red    = s_tdata[10:3];
    assign in_entry.green  = s_tdata[18:11];
    assign in_entry.blue   = s_tdata[26:19];
    assign in_entry.x      = s_tdata[36:27];
    assign in_entry.y      = s_tdata[46:37];
    assign in_entry.depth  = s_tdata[54:47];
    assign in_entry.radius = s_tdata[62:55];
    assign in_row          = s_tdata[72:63];
    assign in_col          = s_tdata[82:73];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign tbl_wr   = accept && (in_op == sps_pkg::OP_LOAD);

    sps_sphere_table #(
        .DEPTH(NUM_SPHERES)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tbl_wr),
        .wr_slot  (in_slot),
        .wr_entry (in_entry),
        .rd_idx   (k_reg),
        .rd_entry (entry)
    );

    // Distances to the current sphere centre, fed through the squarer in turn.
    assign dx = (row_reg >= entry.x) ? row_reg - entry.x : entry.x - row_reg;
    assign dy = (col_reg >= entry.y) ? col_reg - entry.y : entry.y - col_reg;

    always_comb begin
        case (state_reg)
            S_SQX:   sq_operand = dx;
            S_SQY:   sq_operand = dy;
            default: sq_operand = XW'(entry.radius);
        endcase
    end

    sps_square_unit u_square (
        .aclk    (aclk),
        .operand (sq_operand),
        .square  (square)
    );

    // Hit test and shading range; the root is only needed when some channel
    // could still change.
    assign hit        = (dist_reg <= DW'(square));
    assign weighted   = WDW'(dist_reg) * WDW'(WEIGHT);
    assign in_range   = (weighted < WDW'(sps_pkg::SHADE_LIMIT));
    assign root_start = (state_reg == S_HIT) && hit && in_range;
    assign zero_dist  = (dist_reg == '0);

    sps_root_unit u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .operand (weighted[sps_pkg::ROOT_IN_W-1:0]),
        .result  (root_res)
    );

    // Byte address of the pixel, wrapping to its field width.
    assign pixel_index = 32'(col_reg) + 32'(row_reg) * 32'(IMAGE_DIM);
    assign byte_addr   = {pixel_index[sps_pkg::ADDR_W-3:0], 2'b00};
    assign last_sphere = (k_reg == IDX_W'(NUM_SPHERES - 1));

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        k_next        = k_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        dist_next     = dist_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        blue_next     = blue_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (in_op == sps_pkg::OP_SHADE)) begin
                    row_next   = in_row;
                    col_next   = in_col;
                    red_next   = '0;
                    green_next = '0;
                    blue_next  = '0;
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_SQX;
            end
            S_SQX: begin
                state_next = S_SQY;
            end
            S_SQY: begin
                dist_next  = DW'(square);
                state_next = S_RSQ;
            end
            S_RSQ: begin
                dist_next  = dist_reg + DW'(square);
                state_next = S_HIT;
            end
            S_HIT: begin
                if (root_start) begin
                    state_next = S_ROOT;
                end else if (last_sphere) begin
                    state_next = S_EMIT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_ROOT: begin
                if (root_res.done) begin
                    red_next   = shade_chan(red_reg, entry.red, entry.depth,
                                            root_res.floor_root, root_res.inexact,
                                            zero_dist);
                    green_next = shade_chan(green_reg, entry.green, entry.depth,
                                            root_res.floor_root, root_res.inexact,
                                            zero_dist);
                    blue_next  = shade_chan(blue_reg, entry.blue, entry.depth,
                                            root_res.floor_root, root_res.inexact,
                                            zero_dist);
                    if (last_sphere) begin
                        state_next = S_EMIT;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, CW'(sps_pkg::ALPHA_OPAQUE), blue_reg,
                                     green_reg, red_reg, byte_addr};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, output word and working registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        k_reg       <= k_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        dist_reg    <= dist_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/core/sps_checker.sv
module sps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    // Every result word is opaque and word aligned.
    a_result_format: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[53:46] == 8'hFF) && (m_tdata[1:0] == 2'b00)))
        else $error("result word has bad alpha or unaligned address");

    // A shade word keeps the input closed while the table is walked.
    a_shade_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("input taken while a pixel is being shaded");

    // A load word gives no result and leaves the input open.
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser[0] && !m_tvalid) |=> (s_tready && !m_tvalid))
        else $error("load word produced a result or closed the input");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sphere_pixel_shader_unit sps_checker u_sps_checker (.*);
